### rtl/bmh_pkg.sv
// Shared types and constants for the bounded max-heap k-smallest core.
// No dependencies; imported by bmh_cmp and the core.
`default_nettype none

package bmh_pkg;

  localparam int HEAP_DEPTH = 16;
  localparam int KEY_W      = 32;
  localparam int VALUE_W    = 16;
  localparam int IDX_W      = $clog2(HEAP_DEPTH);
  localparam int CNT_W      = $clog2(HEAP_DEPTH + 1);
  localparam int CAP_W      = 5;
  localparam int CHILD_W    = IDX_W + 2;
  localparam int ENTRY_W    = KEY_W + VALUE_W;

  localparam logic REQ_INSERT = 1'b0;
  localparam logic REQ_READ   = 1'b1;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_RD_WAIT,
    ST_RD_OUT,
    ST_UP_RD,
    ST_UP_CMP,
    ST_FULL_RD,
    ST_FULL_CMP,
    ST_DN_RD,
    ST_DN_SEL,
    ST_DN_CMP
  } state_t;

  typedef enum logic [1:0] {
    CMP_CHILDREN,
    CMP_KEY_CHILD,
    CMP_PARENT_KEY,
    CMP_ROOT_KEY
  } cmp_op_t;

endpackage

`default_nettype wire

### rtl/bmh_ram.sv
// Generic one-write, two-read RAM with registered read data.
// Standalone; no package dependency.
`default_nettype none

module bmh_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_a,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_b,
  output logic      [WIDTH-1:0]         rdata_a,
  output logic      [WIDTH-1:0]         rdata_b
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_a <= mem[raddr_a];
    rdata_b <= mem[raddr_b];
  end

endmodule

`default_nettype wire

### rtl/bmh_cmp.sv
// Shared key comparator: picks its two operands by operation and gives a < b.
// Depends on bmh_pkg.
`default_nettype none

module bmh_cmp
  import bmh_pkg::*;
(
  input  wire cmp_op_t              op,
  input  wire logic [ENTRY_W-1:0]   ent_a,
  input  wire logic [ENTRY_W-1:0]   ent_b,
  input  wire logic [KEY_W-1:0]     pair_key,
  input  wire logic [KEY_W-1:0]     child_key,
  output logic                      lt
);

  logic [KEY_W-1:0] opa;
  logic [KEY_W-1:0] opb;

  always_comb begin
    unique case (op) inside
      CMP_CHILDREN: begin
        opa = ent_a[ENTRY_W-1:VALUE_W];
        opb = ent_b[ENTRY_W-1:VALUE_W];
      end
      CMP_KEY_CHILD: begin
        opa = pair_key;
        opb = child_key;
      end
      CMP_PARENT_KEY, CMP_ROOT_KEY: begin
        opa = ent_a[ENTRY_W-1:VALUE_W];
        opb = pair_key;
      end
      default: begin
        opa = pair_key;
        opb = pair_key;
      end
    endcase
  end

  assign lt = opa < opb;

endmodule

`default_nettype wire

### rtl/bounded_max_heap_k_smallest_core.sv
// Bounded max-heap k-smallest core: sequencer, heap RAM and shared comparator.
// Depends on bmh_pkg, bmh_ram and bmh_cmp.
// A read does one RAM read; a full-heap insert compares with the root and is rejected or replaces it;
//   an append sifts up toward the root, and a replacement sifts down toward a leaf.
//   One item at a time; the next may start in the result cycle; no stall.
// Reset (rst_n low, synchronous) empties the heap and sets capacity to 16.
`default_nettype none

module bounded_max_heap_k_smallest_core
  import bmh_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               rst_n,
  // command channel
  input  wire logic               start,
  output logic                    busy,
  input  wire logic               in_req_type,
  input  wire logic [KEY_W-1:0]   in_key_in,
  input  wire logic [VALUE_W-1:0] in_value_in,
  input  wire logic [IDX_W-1:0]   in_read_index,
  // configuration
  input  wire logic               cfg_wr_en,
  input  wire logic [CAP_W-1:0]   cfg_wr_data,
  // result channel
  output logic                    out_strobe,
  output logic                    out_accepted,
  output logic      [KEY_W-1:0]   out_read_key,
  output logic      [VALUE_W-1:0] out_read_value,
  output logic                    out_read_valid,
  output logic      [CNT_W-1:0]   out_entry_count
);

  // Sequencer state and control registers
  state_t             state_r, state_nxt;
  logic [CAP_W-1:0]   cap_r;
  logic [CNT_W-1:0]   fill_r, fill_nxt;
  logic               out_strobe_r, out_strobe_nxt;

  // Payload registers: the pair in flight, the hole position, the chosen child
  logic [KEY_W-1:0]   key_r, key_nxt;
  logic [VALUE_W-1:0] val_r, val_nxt;
  logic [IDX_W-1:0]   idx_r, idx_nxt;
  logic [IDX_W-1:0]   cur_r, cur_nxt;
  logic [IDX_W-1:0]   child_idx_r, child_idx_nxt;
  logic [ENTRY_W-1:0] child_ent_r, child_ent_nxt;
  logic               out_accepted_r, out_accepted_nxt;
  logic [KEY_W-1:0]   out_key_r, out_key_nxt;
  logic [VALUE_W-1:0] out_val_r, out_val_nxt;
  logic               out_valid_r, out_valid_nxt;

  // RAM ports
  logic               ram_we;
  logic [IDX_W-1:0]   ram_waddr;
  logic [ENTRY_W-1:0] ram_wdata;
  logic [IDX_W-1:0]   ram_raddr_a, ram_raddr_b;
  logic [ENTRY_W-1:0] ram_rdata_a, ram_rdata_b;

  // Comparator
  cmp_op_t            cmp_op;
  logic               cmp_lt;

  // Index arithmetic
  logic [CHILD_W-1:0] left_w, right_w;
  logic               left_ok, right_ok;
  logic [IDX_W-1:0]   parent;
  logic [CNT_W-1:0]   cap_eff;
  logic               heap_full;

  bmh_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (HEAP_DEPTH)
  ) u_ram (
    .clk     (clk),
    .we      (ram_we),
    .waddr   (ram_waddr),
    .wdata   (ram_wdata),
    .raddr_a (ram_raddr_a),
    .raddr_b (ram_raddr_b),
    .rdata_a (ram_rdata_a),
    .rdata_b (ram_rdata_b)
  );

  bmh_cmp u_cmp (
    .op        (cmp_op),
    .ent_a     (ram_rdata_a),
    .ent_b     (ram_rdata_b),
    .pair_key  (key_r),
    .child_key (child_ent_r[ENTRY_W-1:VALUE_W]),
    .lt        (cmp_lt)
  );

  // Capacity 0 acts as 1, anything above the depth as the depth.
  always_comb begin
    if (cap_r == '0) begin
      cap_eff = CNT_W'(1);
    end else if ({1'b0, cap_r} > (CAP_W + 1)'(HEAP_DEPTH)) begin
      cap_eff = CNT_W'(HEAP_DEPTH);
    end else begin
      cap_eff = CNT_W'(cap_r);
    end
  end

  assign heap_full = fill_r >= cap_eff;

  // Children of the hole: 2*cur+1 and 2*cur+2, checked against the live count.
  assign left_w   = {1'b0, cur_r, 1'b1};
  assign right_w  = left_w + CHILD_W'(1);
  assign left_ok  = left_w  < CHILD_W'(fill_r);
  assign right_ok = right_w < CHILD_W'(fill_r);
  assign parent   = (cur_r - IDX_W'(1)) >> 1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cap_r        <= CAP_W'(HEAP_DEPTH);
      fill_r       <= '0;
      out_strobe_r <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        cap_r <= cfg_wr_data;
      end
      fill_r       <= fill_nxt;
      out_strobe_r <= out_strobe_nxt;
    end
  end

  always_ff @(posedge clk) begin
    key_r          <= key_nxt;
    val_r          <= val_nxt;
    idx_r          <= idx_nxt;
    cur_r          <= cur_nxt;
    child_idx_r    <= child_idx_nxt;
    child_ent_r    <= child_ent_nxt;
    out_accepted_r <= out_accepted_nxt;
    out_key_r      <= out_key_nxt;
    out_val_r      <= out_val_nxt;
    out_valid_r    <= out_valid_nxt;
  end

  // Sequencer. The inserted pair never sits in the RAM while it moves: a
  // displaced entry is copied into the hole, and the pair is written once
  // where its walk ends.
  always_comb begin
    state_nxt        = state_r;
    fill_nxt         = fill_r;
    out_strobe_nxt   = 1'b0;
    key_nxt          = key_r;
    val_nxt          = val_r;
    idx_nxt          = idx_r;
    cur_nxt          = cur_r;
    child_idx_nxt    = child_idx_r;
    child_ent_nxt    = child_ent_r;
    out_accepted_nxt = out_accepted_r;
    out_key_nxt      = out_key_r;
    out_val_nxt      = out_val_r;
    out_valid_nxt    = out_valid_r;
    ram_we           = 1'b0;
    ram_waddr        = cur_r;
    ram_wdata        = {key_r, val_r};
    ram_raddr_a      = left_w[IDX_W-1:0];
    ram_raddr_b      = right_w[IDX_W-1:0];
    cmp_op           = CMP_CHILDREN;

    unique case (state_r)
      ST_IDLE: begin
        if (start) begin
          key_nxt = in_key_in;
          val_nxt = in_value_in;
          idx_nxt = in_read_index;
          if (in_req_type == REQ_READ) begin
            state_nxt = ST_RD_WAIT;
          end else if (heap_full) begin
            state_nxt = ST_FULL_RD;
          end else begin
            cur_nxt   = fill_r[IDX_W-1:0];
            state_nxt = ST_UP_RD;
          end
        end
      end

      // Read request: one RAM read, zeros past the count.
      ST_RD_WAIT: begin
        ram_raddr_a = idx_r;
        state_nxt   = ST_RD_OUT;
      end

      ST_RD_OUT: begin
        out_strobe_nxt   = 1'b1;
        out_accepted_nxt = 1'b0;
        if (CNT_W'(idx_r) < fill_r) begin
          out_key_nxt   = ram_rdata_a[ENTRY_W-1:VALUE_W];
          out_val_nxt   = ram_rdata_a[VALUE_W-1:0];
          out_valid_nxt = 1'b1;
        end else begin
          out_key_nxt   = '0;
          out_val_nxt   = '0;
          out_valid_nxt = 1'b0;
        end
        state_nxt = ST_IDLE;
      end

      // Sift up: fetch the parent, or settle at the root.
      ST_UP_RD: begin
        ram_raddr_a = parent;
        if (cur_r == '0) begin
          ram_we           = 1'b1;
          fill_nxt         = fill_r + CNT_W'(1);
          out_strobe_nxt   = 1'b1;
          out_accepted_nxt = 1'b1;
          out_key_nxt      = '0;
          out_val_nxt      = '0;
          out_valid_nxt    = 1'b0;
          state_nxt        = ST_IDLE;
        end else begin
          state_nxt = ST_UP_CMP;
        end
      end

      // Move the parent down only while the pair's key is strictly larger.
      ST_UP_CMP: begin
        cmp_op = CMP_PARENT_KEY;
        ram_we = 1'b1;
        if (cmp_lt) begin
          ram_wdata = ram_rdata_a;
          cur_nxt   = parent;
          state_nxt = ST_UP_RD;
        end else begin
          fill_nxt         = fill_r + CNT_W'(1);
          out_strobe_nxt   = 1'b1;
          out_accepted_nxt = 1'b1;
          out_key_nxt      = '0;
          out_val_nxt      = '0;
          out_valid_nxt    = 1'b0;
          state_nxt        = ST_IDLE;
        end
      end

      // Full heap: fetch the root.
      ST_FULL_RD: begin
        ram_raddr_a = '0;
        state_nxt   = ST_FULL_CMP;
      end

      // Drop the pair if its key exceeds the root; an equal key replaces it.
      ST_FULL_CMP: begin
        cmp_op = CMP_ROOT_KEY;
        if (cmp_lt) begin
          out_strobe_nxt   = 1'b1;
          out_accepted_nxt = 1'b0;
          out_key_nxt      = '0;
          out_val_nxt      = '0;
          out_valid_nxt    = 1'b0;
          state_nxt        = ST_IDLE;
        end else begin
          cur_nxt   = '0;
          state_nxt = ST_DN_RD;
        end
      end

      // Sift down: fetch both children, or settle at a leaf.
      ST_DN_RD: begin
        if (!left_ok) begin
          ram_we           = 1'b1;
          out_strobe_nxt   = 1'b1;
          out_accepted_nxt = 1'b1;
          out_key_nxt      = '0;
          out_val_nxt      = '0;
          out_valid_nxt    = 1'b0;
          state_nxt        = ST_IDLE;
        end else begin
          state_nxt = ST_DN_SEL;
        end
      end

      // Take the right child only when the left key is strictly smaller.
      ST_DN_SEL: begin
        cmp_op = CMP_CHILDREN;
        if (right_ok && cmp_lt) begin
          child_idx_nxt = right_w[IDX_W-1:0];
          child_ent_nxt = ram_rdata_b;
        end else begin
          child_idx_nxt = left_w[IDX_W-1:0];
          child_ent_nxt = ram_rdata_a;
        end
        state_nxt = ST_DN_CMP;
      end

      // Lift the child while its key is strictly larger than the pair's.
      ST_DN_CMP: begin
        cmp_op = CMP_KEY_CHILD;
        ram_we = 1'b1;
        if (cmp_lt) begin
          ram_wdata = child_ent_r;
          cur_nxt   = child_idx_r;
          state_nxt = ST_DN_RD;
        end else begin
          out_strobe_nxt   = 1'b1;
          out_accepted_nxt = 1'b1;
          out_key_nxt      = '0;
          out_val_nxt      = '0;
          out_valid_nxt    = 1'b0;
          state_nxt        = ST_IDLE;
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  assign busy            = (state_r != ST_IDLE);
  assign out_strobe      = out_strobe_r;
  assign out_accepted    = out_accepted_r;
  assign out_read_key    = out_key_r;
  assign out_read_value  = out_val_r;
  assign out_read_valid  = out_valid_r;
  assign out_entry_count = fill_r;

endmodule

`default_nettype wire
